// ===== hdl/blir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package blir_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int REQ_W         = 3;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_BACK  = 3'd1,
        REQ_REM_FRONT = 3'd2,
        REQ_REM_BACK  = 3'd3,
        REQ_REM_MATCH = 3'd4
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP_RD,
        ST_POP_TAKE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        ADDR_POS,
        ADDR_POS_NEXT,
        ADDR_COUNT,
        ADDR_FRONT_DEC
    } addr_sel_t;

    typedef struct packed {
        logic      latch_in;
        logic      set_pos_zero;
        logic      set_pos_last;
        logic      inc_pos;
        addr_sel_t addr_sel;
        logic      mem_we;
        logic      wr_shift;
        logic      front_dec;
        logic      front_inc;
        logic      count_inc;
        logic      count_dec;
        logic      capture_removed;
        logic      set_status;
        status_t   status_code;
        logic      load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             is_full;
        logic             is_empty;
        logic             match;
        logic             pos_last;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/blir_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module blir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/blir_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module blir_dp #(
    parameter int DEPTH = blir_pkg::DEFAULT_DEPTH
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire blir_pkg::dp_cmd_t                  cmd,
    output blir_pkg::dp_stat_t                      stat,
    input  wire logic [blir_pkg::REQ_W-1:0]         s_req_type,
    input  wire logic signed [blir_pkg::VALUE_W-1:0] s_value,
    output logic [blir_pkg::STATUS_W-1:0]           m_status,
    output logic signed [blir_pkg::VALUE_W-1:0]     m_removed_value,
    output logic [$clog2(DEPTH+1)-1:0]              m_entry_count
);

    import blir_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

    logic [REQ_W-1:0]   req_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [AW-1:0]      pos_reg;
    logic [AW-1:0]      front_reg;
    logic [CW-1:0]      count_reg;
    status_t            status_reg;
    logic [VALUE_W-1:0] removed_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [VALUE_W-1:0] m_removed_reg;
    logic [CW-1:0]      m_count_reg;

    logic [AW-1:0]      offset;
    logic [AW:0]        sum;
    logic [AW-1:0]      slot;
    logic [AW-1:0]      front_dec;
    logic [AW-1:0]      front_inc;
    logic [AW-1:0]      addr;
    logic [VALUE_W-1:0] rdata;
    logic [VALUE_W-1:0] wdata;

    always_comb begin
        case (cmd.addr_sel)
            ADDR_POS_NEXT: offset = pos_reg + AW'(1);
            ADDR_COUNT:    offset = count_reg[AW-1:0];
            default:       offset = pos_reg;
        endcase
        sum = {1'b0, front_reg} + {1'b0, offset};
        if (sum >= DEPTH_W) begin
            slot = AW'(sum - DEPTH_W);
        end else begin
            slot = sum[AW-1:0];
        end
        front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
        front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + AW'(1);
        addr      = (cmd.addr_sel == ADDR_FRONT_DEC) ? front_dec : slot;
        wdata     = cmd.wr_shift ? rdata : value_reg;
    end

    blir_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (cmd.mem_we),
        .waddr(addr),
        .wdata(wdata),
        .raddr(addr),
        .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.front_dec) begin
                front_reg <= front_dec;
            end else if (cmd.front_inc) begin
                front_reg <= front_inc;
            end
            if (cmd.count_inc) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.count_dec) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            req_reg     <= s_req_type;
            value_reg   <= s_value;
            status_reg  <= STATUS_DONE;
            removed_reg <= '0;
        end else begin
            if (cmd.set_status) begin
                status_reg <= cmd.status_code;
            end
            if (cmd.capture_removed) begin
                removed_reg <= rdata;
            end
        end
        if (cmd.set_pos_zero) begin
            pos_reg <= '0;
        end else if (cmd.set_pos_last) begin
            pos_reg <= AW'(count_reg - CW'(1));
        end else if (cmd.inc_pos) begin
            pos_reg <= pos_reg + AW'(1);
        end
        if (cmd.load_out) begin
            m_status_reg  <= status_reg;
            m_removed_reg <= removed_reg;
            m_count_reg   <= count_reg;
        end
    end

    assign stat.req      = req_reg;
    assign stat.is_full  = (count_reg == CW'(DEPTH));
    assign stat.is_empty = (count_reg == '0);
    assign stat.match    = (rdata == value_reg);
    assign stat.pos_last = ((CW'(pos_reg) + CW'(1)) == count_reg);

    assign m_status        = m_status_reg;
    assign m_removed_value = m_removed_reg;
    assign m_entry_count   = m_count_reg;

    property p_count_step;
        @(posedge aclk) disable iff (!aresetn)
            1'b1 |=> (count_reg == $past(count_reg)) ||
                     (count_reg == $past(count_reg) + CW'(1)) ||
                     (count_reg == $past(count_reg) - CW'(1));
    endproperty
    a_count_step: assert property (p_count_step)
        else $error("Entry count moved by more than one in a cycle.");

    property p_no_write_full;
        @(posedge aclk) disable iff (!aresetn)
            (cmd.mem_we && !cmd.wr_shift) |-> (count_reg != CW'(DEPTH));
    endproperty
    a_no_write_full: assert property (p_no_write_full)
        else $error("Insert write issued into a full list.");

    property p_count_bound;
        @(posedge aclk) disable iff (!aresetn)
            1'b1 |-> (count_reg <= CW'(DEPTH));
    endproperty
    a_count_bound: assert property (p_count_bound)
        else $error("Entry count exceeds the list depth.");

endmodule

`default_nettype wire

// ===== hdl/blir_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module blir_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire blir_pkg::dp_stat_t  stat,
    output blir_pkg::dp_cmd_t        cmd,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready
);

    import blir_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        cmd          = '0;
        cmd.addr_sel = ADDR_POS;
        state_next   = state_reg;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_RESP;
                unique case (stat.req) inside
                    REQ_INS_FRONT, REQ_INS_BACK: begin
                        if (stat.is_full) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STATUS_FULL;
                        end else begin
                            cmd.mem_we    = 1'b1;
                            cmd.count_inc = 1'b1;
                            if (stat.req == REQ_INS_FRONT) begin
                                cmd.addr_sel  = ADDR_FRONT_DEC;
                                cmd.front_dec = 1'b1;
                            end else begin
                                cmd.addr_sel = ADDR_COUNT;
                            end
                        end
                    end
                    REQ_REM_FRONT, REQ_REM_BACK, REQ_REM_MATCH: begin
                        if (stat.is_empty) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STATUS_EMPTY;
                        end else if (stat.req == REQ_REM_BACK) begin
                            cmd.set_pos_last = 1'b1;
                            state_next       = ST_POP_RD;
                        end else begin
                            cmd.set_pos_zero = 1'b1;
                            state_next = (stat.req == REQ_REM_MATCH) ? ST_SCAN_RD : ST_POP_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_POP_RD: begin
                state_next = ST_POP_TAKE;
            end
            ST_POP_TAKE: begin
                cmd.capture_removed = 1'b1;
                cmd.count_dec       = 1'b1;
                cmd.front_inc       = (stat.req == REQ_REM_FRONT);
                state_next          = ST_RESP;
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (stat.match) begin
                    cmd.capture_removed = 1'b1;
                    state_next          = ST_SHIFT_RD;
                end else if (stat.pos_last) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STATUS_NOT_FOUND;
                    state_next      = ST_RESP;
                end else begin
                    cmd.inc_pos = 1'b1;
                    state_next  = ST_SCAN_RD;
                end
            end
            ST_SHIFT_RD: begin
                if (stat.pos_last) begin
                    cmd.count_dec = 1'b1;
                    state_next    = ST_RESP;
                end else begin
                    cmd.addr_sel = ADDR_POS_NEXT;
                    state_next   = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                cmd.mem_we   = 1'b1;
                cmd.wr_shift = 1'b1;
                cmd.inc_pos  = 1'b1;
                state_next   = ST_SHIFT_RD;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== hdl/bounded_list_insert_remove_by_value.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_req_type, s_value
// m_        out        m_valid / m_ready    m_status, m_removed_value, m_entry_count
//
// Inserts and failed or ignored requests pass through the execute and response states.
// Front and back removes add one read of the single-port entry RAM.
// Remove by value reads and compares each entry in turn and, when the value is found,
// moves each later entry one place toward the front with a read and then a write of the
// entry RAM, which shares one address between its registered read and its write.
// Reset clears the front pointer and the count; entries are never read outside the list.
// A stalled result holds in the output register while the next request is processed.

module bounded_list_insert_remove_by_value #(
    parameter int DEPTH = blir_pkg::DEFAULT_DEPTH
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [blir_pkg::REQ_W-1:0]          s_req_type,
    input  wire logic signed [blir_pkg::VALUE_W-1:0] s_value,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [blir_pkg::STATUS_W-1:0]            m_status,
    output logic signed [blir_pkg::VALUE_W-1:0]      m_removed_value,
    output logic [$clog2(DEPTH+1)-1:0]               m_entry_count
);

    import blir_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    blir_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .stat   (stat),
        .cmd    (cmd),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready)
    );

    blir_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_req_type     (s_req_type),
        .s_value        (s_value),
        .m_status       (m_status),
        .m_removed_value(m_removed_value),
        .m_entry_count  (m_entry_count)
    );

    property p_empty_result;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid && (m_status == STATUS_EMPTY)) |->
                ((m_entry_count == '0) && (m_removed_value == '0));
    endproperty
    a_empty_result: assert property (p_empty_result)
        else $error("Empty status with a nonzero count or removed value.");

    property p_full_result;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid && (m_status == STATUS_FULL)) |->
                ((m_entry_count == CW'(DEPTH)) && (m_removed_value == '0));
    endproperty
    a_full_result: assert property (p_full_result)
        else $error("Full status while the list is not full.");

    property p_no_accept_busy;
        @(posedge aclk) disable iff (!aresetn)
            (s_valid && s_ready) |=> !s_ready;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy)
        else $error("Request accepted while the previous one is in progress.");

endmodule

`default_nettype wire

// ===== bench/bounded_list_insert_remove_by_value_tb.sv =====
`timescale 1ns / 1ps

module bounded_list_insert_remove_by_value_tb;
    import blir_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int DEPTH         = 16;
    localparam int PTR_W         = $clog2(DEPTH);
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int RANDOM_ITEMS  = 1700;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 4 + 4 * DEPTH + 16;

    localparam logic [REQ_W-1:0]   REQ_UNUSED_FIRST = 3'd5;
    localparam logic [REQ_W-1:0]   REQ_UNUSED_LAST  = 3'd7;
    localparam logic [VALUE_W-1:0] VALUE_MIN        = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VALUE_MAX        = 32'h7fff_ffff;
    localparam logic [VALUE_W-1:0] VALUE_ONES       = 32'hffff_ffff;

    typedef struct {
        status_t            status;
        logic [VALUE_W-1:0] removed;
        logic [CNT_W-1:0]   count;
    } list_result_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [REQ_W-1:0]          s_req_type;
    logic signed [VALUE_W-1:0] s_value;
    logic                      m_valid;
    logic                      m_ready;
    logic [STATUS_W-1:0]       m_status;
    logic signed [VALUE_W-1:0] m_removed_value;
    logic [CNT_W-1:0]          m_entry_count;

    logic [VALUE_W-1:0] list_store [DEPTH];
    logic [PTR_W-1:0]   list_front;
    logic [CNT_W-1:0]   list_count;

    list_result_t pending_results[$];
    int           error_count    = 0;
    int           requests_sent  = 0;
    int           peak_count     = 0;
    int           burst_left     = 0;
    int           status_seen[4] = '{0, 0, 0, 0};
    bit           long_hold_req  = 1'b0;

    bounded_list_insert_remove_by_value #(
        .DEPTH(DEPTH)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_removed_value(m_removed_value),
        .m_entry_count  (m_entry_count)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic [PTR_W-1:0] slot_at(int pos);
        return PTR_W'((int'(list_front) + pos) % DEPTH);
    endfunction

    function automatic list_result_t apply_request(logic [REQ_W-1:0] req,
                                                   logic [VALUE_W-1:0] val);
        list_result_t r;
        int           pos;
        bit           hit;
        r.status  = STATUS_DONE;
        r.removed = '0;
        hit       = 1'b0;
        case (req)
            REQ_INS_FRONT, REQ_INS_BACK: begin
                if (list_count == DEPTH) begin
                    r.status = STATUS_FULL;
                end else if (req == REQ_INS_FRONT) begin
                    list_front = PTR_W'((int'(list_front) + DEPTH - 1) % DEPTH);
                    list_store[list_front] = val;
                    list_count++;
                end else begin
                    list_store[slot_at(list_count)] = val;
                    list_count++;
                end
            end
            REQ_REM_FRONT: begin
                if (list_count == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    r.removed  = list_store[list_front];
                    list_front = slot_at(1);
                    list_count--;
                end
            end
            REQ_REM_BACK: begin
                if (list_count == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    r.removed = list_store[slot_at(list_count - 1)];
                    list_count--;
                end
            end
            REQ_REM_MATCH: begin
                if (list_count == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    for (pos = 0; pos < list_count; pos++) begin
                        if (list_store[slot_at(pos)] == val) begin
                            hit = 1'b1;
                            break;
                        end
                    end
                    if (!hit) begin
                        r.status = STATUS_NOT_FOUND;
                    end else begin
                        r.removed = list_store[slot_at(pos)];
                        for (; pos + 1 < list_count; pos++) begin
                            list_store[slot_at(pos)] = list_store[slot_at(pos + 1)];
                        end
                        list_count--;
                    end
                end
            end
            default: begin
            end
        endcase
        r.count = list_count;
        if (list_count > peak_count) begin
            peak_count = list_count;
        end
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 5))
            0: return VALUE_W'($urandom_range(0, 7));
            1: begin
                case ($urandom_range(0, 3))
                    0: return VALUE_MIN;
                    1: return VALUE_MAX;
                    2: return VALUE_ONES;
                    default: return '0;
                endcase
            end
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    task automatic send_request(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] val);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_value    <= val;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        pending_results.push_back(apply_request(req, val));
        requests_sent++;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string field, input logic [VALUE_W-1:0] want,
                                   input logic [VALUE_W-1:0] got);
        error_count++;
        $error("%s mismatch: expected 0x%08h, actual 0x%08h", field, want, got);
    endtask

    initial begin : result_checker
        list_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                status_seen[m_status]++;
                if (pending_results.size() == 0) begin
                    error_count++;
                    $error("Result with no outstanding request: status %0d", m_status);
                end else begin
                    want = pending_results.pop_front();
                    if (m_status !== want.status) begin
                        report_mismatch("status", VALUE_W'(want.status), VALUE_W'(m_status));
                    end
                    if (m_removed_value !== want.removed) begin
                        report_mismatch("removed_value", want.removed, m_removed_value);
                    end
                    if (m_entry_count !== want.count) begin
                        report_mismatch("entry_count", VALUE_W'(want.count),
                                        VALUE_W'(m_entry_count));
                    end
                end
            end
        end
    end

    initial begin : receiver
        int ready_mode;
        int seg_left;
        int hold_left;
        int phase;
        ready_mode = 0;
        seg_left   = 0;
        hold_left  = 0;
        phase      = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    ready_mode = $urandom_range(0, 3);
                    seg_left   = $urandom_range(8, 80);
                end
                seg_left--;
                case (ready_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (phase % 3 != 0);
                endcase
            end
        end
    end

    task automatic test_empty_removes();
        send_request(REQ_REM_FRONT, '0);
        send_request(REQ_REM_BACK, VALUE_ONES);
        send_request(REQ_REM_MATCH, '0);
        wait_for_results();
    endtask

    task automatic test_extremes_and_unused_codes();
        int code;
        send_request(REQ_INS_FRONT, VALUE_MIN);
        send_request(REQ_INS_BACK, VALUE_MAX);
        send_request(REQ_INS_FRONT, '0);
        send_request(REQ_INS_BACK, VALUE_ONES);
        send_request(REQ_REM_MATCH, 32'd12345);
        send_request(REQ_REM_MATCH, VALUE_MAX);
        for (code = REQ_UNUSED_FIRST; code <= REQ_UNUSED_LAST; code++) begin
            send_request(REQ_W'(code), VALUE_ONES);
        end
        send_request(REQ_REM_FRONT, '0);
        send_request(REQ_REM_BACK, '0);
        // The last entry goes by value, leaving the list empty.
        send_request(REQ_REM_MATCH, VALUE_MIN);
        wait_for_results();
    endtask

    task automatic test_first_match_of_duplicates();
        send_request(REQ_INS_BACK, 32'd7);
        send_request(REQ_INS_BACK, 32'd9);
        send_request(REQ_INS_BACK, 32'd7);
        send_request(REQ_REM_MATCH, 32'd7);
        send_request(REQ_REM_FRONT, '0);
        send_request(REQ_REM_BACK, '0);
        wait_for_results();
    endtask

    task automatic test_fill_under_backpressure();
        int n;
        long_hold_req = 1'b1;
        burst_left    = 64;
        for (n = 0; n < DEPTH + 2; n++) begin
            send_request(n[0] ? REQ_INS_FRONT : REQ_INS_BACK, random_value());
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int               n;
        int               pick;
        int               phase_left;
        bit               grow;
        logic [REQ_W-1:0] req;
        logic [VALUE_W-1:0] val;
        phase_left = 0;
        grow       = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                grow       = ~grow;
                phase_left = $urandom_range(10, 60);
            end
            phase_left--;
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                req = REQ_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
            end else if (pick < (grow ? 75 : 30)) begin
                req = $urandom_range(0, 1) ? REQ_INS_BACK : REQ_INS_FRONT;
            end else begin
                case ($urandom_range(0, 4))
                    0: req = REQ_REM_FRONT;
                    1: req = REQ_REM_BACK;
                    default: req = REQ_REM_MATCH;
                endcase
            end
            if (req == REQ_REM_MATCH && list_count != 0 && $urandom_range(0, 9) < 7) begin
                val = list_store[slot_at($urandom_range(0, list_count - 1))];
            end else begin
                val = random_value();
            end
            send_request(req, val);
        end
        wait_for_results();
    endtask

    initial begin : main
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_req_type <= '0;
        s_value    <= '0;
        list_front = '0;
        list_count = '0;
        foreach (list_store[i]) list_store[i] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_removes();
        test_extremes_and_unused_codes();
        test_first_match_of_duplicates();
        test_fill_under_backpressure();
        test_random_traffic();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Ran %0d requests, list filled up to %0d of %0d entries,",
                 requests_sent, peak_count, DEPTH);
        $display("with a %0d-cycle output stall.", LONG_HOLD);
        $display("Results: %0d done, %0d empty, %0d full, %0d not found.",
                 status_seen[STATUS_DONE], status_seen[STATUS_EMPTY],
                 status_seen[STATUS_FULL], status_seen[STATUS_NOT_FOUND]);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
